// ----- hw/rtl/mmn_pkg.sv -----
// Shared types for the min-max normalizer: controller states, command and status groups.
`timescale 1ns / 1ps

package mmn_pkg;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_WAIT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;    // take the sample of the accepted transaction
		logic rd;      // read the store at the emit index
		logic div_go;  // start the divider on the sample just read
		logic emit;    // register one result and advance or close the set
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic flat;     // maximum equals minimum
		logic div_done; // quotient is ready
		logic is_last;  // emit index points at the last stored sample
	} status_t;

endpackage

// ----- hw/rtl/mmn_divider.sv -----
// Restoring divider: floor(num * 2^FRAC_BITS / den) for num <= den, one quotient bit per cycle.
`timescale 1ns / 1ps

module mmn_divider #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [SAMPLE_BITS-1:0] num,
	input  logic [SAMPLE_BITS-1:0] den,
	output logic                   done,
	output logic [FRAC_BITS:0]     quo
);

	localparam int CNTW = $clog2(FRAC_BITS + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CNTW-1:0]        cnt_q;
	logic [SAMPLE_BITS:0]   rem_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [FRAC_BITS:0]     quo_q;

	logic [SAMPLE_BITS:0]   trial;
	logic                   fits;

	// The first step takes the integer bit, so the remainder is not doubled yet
	always_comb begin
		if (cnt_q == '0) begin
			trial = rem_q;
		end else begin
			trial = {rem_q[SAMPLE_BITS-1:0], 1'b0};
		end
		fits = (trial >= {1'b0, den_q});
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(FRAC_BITS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Data: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= trial - {1'b0, den_q};
			end else begin
				rem_q <= trial;
			end
			quo_q <= {quo_q[FRAC_BITS-1:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- hw/rtl/mmn_datapath.sv -----
// Datapath: sample store, running extremes, counters, divider and result registers.
`timescale 1ns / 1ps

module mmn_datapath #(
	parameter int MAX_SAMPLES = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mmn_pkg::cmd_t                 cmd,
	output mmn_pkg::status_t              status,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          result_valid,
	output logic [FRAC_BITS:0]            scaled,
	output logic                          last_result,
	output logic                          degenerate,
	output logic                          overflowed,
	output logic signed [SAMPLE_BITS-1:0] range_min,
	output logic signed [SAMPLE_BITS-1:0] range_max
);

	import mmn_pkg::*;

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
	logic signed [SAMPLE_BITS-1:0] rd_data_q;
	logic [CW-1:0]                 count_q;
	logic [AW-1:0]                 idx_q;
	logic                          drop_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;

	logic                          room;
	logic [SAMPLE_BITS:0]          num_ext;
	logic [SAMPLE_BITS:0]          span_ext;
	logic                          div_done;
	logic [FRAC_BITS:0]            div_quo;

	logic                          valid_q;
	logic [FRAC_BITS:0]            scaled_q;
	logic                          last_q;
	logic                          degen_q;
	logic                          ovf_q;
	logic signed [SAMPLE_BITS-1:0] rmin_q;
	logic signed [SAMPLE_BITS-1:0] rmax_q;

	assign room = (count_q < CW'(MAX_SAMPLES));

	// Offsets from the minimum; both are known to be non-negative
	assign num_ext  = {rd_data_q[SAMPLE_BITS-1], rd_data_q} - {min_q[SAMPLE_BITS-1], min_q};
	assign span_ext = {max_q[SAMPLE_BITS-1], max_q} - {min_q[SAMPLE_BITS-1], min_q};

	assign status.flat     = (max_q == min_q);
	assign status.div_done = div_done;
	assign status.is_last  = ((CW'(idx_q) + CW'(1)) == count_q);

	// Sample store
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			mem[count_q[AW-1:0]] <= sample;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[idx_q];
		end
	end

	// Running extremes
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			if (count_q == '0) begin
				min_q <= sample;
				max_q <= sample;
			end else begin
				if (sample < min_q) begin
					min_q <= sample;
				end
				if (sample > max_q) begin
					max_q <= sample;
				end
			end
		end
	end

	// Fill count, emit index and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (room) begin
					count_q <= count_q + CW'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				if (status.is_last) begin
					count_q <= '0;
					idx_q   <= '0;
					drop_q  <= 1'b0;
				end else begin
					idx_q <= idx_q + AW'(1);
				end
			end
		end
	end

	mmn_divider #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (cmd.div_go),
		.num   (num_ext[SAMPLE_BITS-1:0]),
		.den   (span_ext[SAMPLE_BITS-1:0]),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			scaled_q <= status.flat ? '0 : div_quo;
			last_q   <= status.is_last;
			degen_q  <= status.flat;
			ovf_q    <= drop_q;
			rmin_q   <= min_q;
			rmax_q   <= max_q;
		end
	end

	assign result_valid = valid_q;
	assign scaled       = scaled_q;
	assign last_result  = last_q;
	assign degenerate   = degen_q;
	assign overflowed   = ovf_q;
	assign range_min    = rmin_q;
	assign range_max    = rmax_q;

endmodule

// ----- hw/rtl/mmn_ctrl.sv -----
// Controller: sequences sample loading and the per-sample emit loop.
`timescale 1ns / 1ps

module mmn_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             last_sample,
	input  mmn_pkg::status_t status,
	output mmn_pkg::cmd_t    cmd,
	output logic             busy
);

	import mmn_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (last_sample) begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_CALC;
			end
			ST_CALC: begin
				if (status.flat) begin
					cmd.emit = 1'b1;
					state_d  = status.is_last ? ST_IDLE : ST_READ;
				end else begin
					cmd.div_go = 1'b1;
					state_d    = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (status.div_done) begin
					cmd.emit = 1'b1;
					state_d  = status.is_last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/min_max_normalizer.sv -----
// Top level of the min-max normalizer: controller, datapath and checks.
`timescale 1ns / 1ps

// Samples of one data set are loaded one per cycle while busy is low; each
// is stored (up to MAX_SAMPLES, later ones are dropped and flagged) and the
// running minimum and maximum are tracked. The sample marked last closes
// the set: busy goes high and every stored sample is emitted in arrival
// order as (x-min)/(max-min) in unsigned Q1.FRAC_BITS. Each result takes
// one store read, a start of the divider, FRAC_BITS+1 steps of the shared
// restoring divider and a write into the result register; when max equals
// min no divide is needed and each result takes only the store read and
// the write into the result register.
// Results appear for exactly one cycle on result_valid and must be taken
// then; there is no way to hold them off. busy drops in the cycle the final
// result is shown, so the next set can start right away.

module min_max_normalizer #(
	parameter int MAX_SAMPLES = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	output logic                          result_valid,
	output logic [FRAC_BITS:0]            scaled,
	output logic                          last_result,
	output logic                          degenerate,
	output logic                          overflowed,
	output logic signed [SAMPLE_BITS-1:0] range_min,
	output logic signed [SAMPLE_BITS-1:0] range_max
);

	import mmn_pkg::*;

	cmd_t    cmd;
	status_t status;

	mmn_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_sample(last_sample),
		.status     (status),
		.cmd        (cmd),
		.busy       (busy)
	);

	mmn_datapath #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.sample      (sample),
		.result_valid(result_valid),
		.scaled      (scaled),
		.last_result (last_result),
		.degenerate  (degenerate),
		.overflowed  (overflowed),
		.range_min   (range_min),
		.range_max   (range_max)
	);

`ifndef ASSERT_OFF
	// Two results are never shown back to back
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("results on consecutive cycles");

	// A closing sample starts the emit sequence
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_sample) |=> busy)
		else $error("busy not raised after the closing sample");

	// Only the final result of a set frees the block
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last_result == !busy))
		else $error("busy does not match the final result");

	// A degenerate set always reports zero
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && degenerate) |-> (scaled == '0))
		else $error("degenerate result not zero");
`endif

endmodule
